// ----- src/cpct_pkg.sv -----
// ---------------------------------------------------------------------------
// cpct_pkg: shared types and constants
// Field widths, item kinds, register indexes and the structs that travel
// along the row of table cells.
// ---------------------------------------------------------------------------
package cpct_pkg;

  localparam int unsigned HANDLE_W = 12;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned REPORT_W = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 8;
  localparam int unsigned IN_DW    = 32;
  localparam int unsigned OUT_DW   = 16;

  // Item kinds carried on in_tuser.
  localparam logic [MODE_W-1:0] MODE_SEND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_MAX_PACKETS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TX_ENABLED  = 2'd1;

  localparam logic [COUNT_W-1:0] MAX_PACKETS_RST = 8'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } cpct_state_t;

  // Lookup token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic                hit;
    logic                free_seen;
    logic [COUNT_W-1:0]  count;
  } cpct_tok_t;

  // Entry update broadcast to the cells when an item commits.
  typedef struct packed {
    logic                en;
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
  } cpct_wr_t;

  function automatic logic [COUNT_W-1:0] free_slots(input logic [COUNT_W-1:0] limit,
                                                    input logic [COUNT_W-1:0] total);
    free_slots = (limit > total) ? COUNT_W'(limit - total) : '0;
  endfunction

endpackage

// ----- src/cpct_cell.sv -----
// ---------------------------------------------------------------------------
// cpct_cell: one table entry of the credit tracker
// Holds a handle and its pending count, updates the passing lookup token
// and hands it to the next cell.
// ---------------------------------------------------------------------------
module cpct_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpct_pkg::cpct_tok_t tok_i,
  input  logic [IDX_W-1:0]    hit_idx_i,
  input  logic [IDX_W-1:0]    free_idx_i,
  output cpct_pkg::cpct_tok_t tok_o,
  output logic [IDX_W-1:0]    hit_idx_o,
  output logic [IDX_W-1:0]    free_idx_o,
  input  cpct_pkg::cpct_wr_t  wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                          valid_r;
  logic [cpct_pkg::HANDLE_W-1:0] handle_r;
  logic [cpct_pkg::COUNT_W-1:0]  count_r;
  cpct_pkg::cpct_tok_t           tok_r, tok_nxt;
  logic [IDX_W-1:0]              hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic                          match;

  assign match = valid_r && (handle_r == tok_i.handle);

  always_comb begin
    tok_nxt      = tok_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    if (match) begin
      tok_nxt.hit   = 1'b1;
      tok_nxt.count = count_r;
      hit_idx_nxt   = MY_IDX;
    end
    // The lowest free entry is the first one the token meets.
    if (!valid_r && !tok_i.free_seen) begin
      tok_nxt.free_seen = 1'b1;
      free_idx_nxt      = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_i.en && (wr_idx_i == MY_IDX)) begin
        valid_r <= wr_i.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (wr_i.en && (wr_idx_i == MY_IDX)) begin
      handle_r <= wr_i.handle;
      count_r  <= wr_i.count;
    end
  end

  assign tok_o      = tok_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;

endmodule

// ----- src/completed_packet_credit_tracker_core.sv -----
// ---------------------------------------------------------------------------
// completed_packet_credit_tracker_core: packet-based transmit flow control
// Tracks packets sent but not yet reported complete, per connection handle,
// against a limit of controller buffer slots.
// ---------------------------------------------------------------------------
// A request is accepted and its lookup token walks the row of table cells,
// one cell per cycle, starting at the edge of acceptance, to find the
// handle's entry and the lowest free entry. What it found is latched at the
// end of the row, then the DONE state commits the update and loads the
// result register, which drives the output. The next request is accepted at
// the earliest in the cycle after the previous one has been committed to the
// table, since in_tready is high only in IDLE.
// A result that is not taken holds back the commit
// of the following request. A request carries its kind on in_tuser (0 send,
// 1 completed-packets report, 2 clear handle) and gets exactly one result. The
// result register decouples the two sides, so a new request is taken while a
// result still waits on the output. Configuration is written through cfg_we,
// cfg_addr and cfg_wdata and must only be changed while no request is in flight.
// ---------------------------------------------------------------------------
module completed_packet_credit_tracker_core #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [11:0] handle, [27:12] report_count, [31:28] zero
  input  logic [cpct_pkg::IN_DW-1:0]          in_tdata,
  // [1:0] mode
  input  logic [cpct_pkg::MODE_W-1:0]         in_tuser,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] granted, [8:1] free_slots, [9] clamped, [10] unknown_handle,
  // [11] table_full, [15:12] zero
  output logic [cpct_pkg::OUT_DW-1:0]         out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [cpct_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [cpct_pkg::CFG_DW-1:0]         cfg_wdata
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW    = cpct_pkg::COUNT_W;

  // Configuration registers.
  logic [CW-1:0] max_packets_r;
  logic          tx_enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packets_r <= cpct_pkg::MAX_PACKETS_RST;
      tx_enabled_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cpct_pkg::REG_MAX_PACKETS: max_packets_r <= cfg_wdata[CW-1:0];
        cpct_pkg::REG_TX_ENABLED:  tx_enabled_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Control state.
  cpct_pkg::cpct_state_t state_r, state_nxt;
  logic [CW-1:0]         total_r, total_nxt;
  logic                  out_valid_r;
  logic [cpct_pkg::OUT_DW-1:0] out_data_r, out_data_nxt;

  // Request held while the lookup runs.
  logic [cpct_pkg::MODE_W-1:0]   mode_r;
  logic [cpct_pkg::REPORT_W-1:0] report_r;

  // What the token found at the end of the row.
  cpct_pkg::cpct_tok_t res_r;
  logic [IDX_W-1:0]    res_hit_idx_r, res_free_idx_r;

  logic in_accept, commit, inject, last_seen;

  // Chain of cells.
  cpct_pkg::cpct_tok_t tok   [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]    hidx  [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]    fidx  [0:TABLE_ENTRIES];
  cpct_pkg::cpct_wr_t  wr;
  logic [IDX_W-1:0]    wr_idx;

  assign tok[0].valid     = inject;
  assign tok[0].handle    = in_tdata[cpct_pkg::HANDLE_W-1:0];
  assign tok[0].hit       = 1'b0;
  assign tok[0].free_seen = 1'b0;
  assign tok[0].count     = '0;
  assign hidx[0]          = '0;
  assign fidx[0]          = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cpct_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok[g]),
      .hit_idx_i  (hidx[g]),
      .free_idx_i (fidx[g]),
      .tok_o      (tok[g+1]),
      .hit_idx_o  (hidx[g+1]),
      .free_idx_o (fidx[g+1]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx)
    );
  end

  assign last_seen = tok[TABLE_ENTRIES].valid;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpct_pkg::ST_IDLE: if (in_tvalid) state_nxt = cpct_pkg::ST_SCAN;
      cpct_pkg::ST_SCAN: if (last_seen) state_nxt = cpct_pkg::ST_DONE;
      cpct_pkg::ST_DONE: if (!out_valid_r || out_tready) state_nxt = cpct_pkg::ST_IDLE;
      default:           state_nxt = cpct_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      cpct_pkg::ST_IDLE: in_tready = 1'b1;
      cpct_pkg::ST_DONE: commit    = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_accept = in_tvalid && in_tready;
  assign inject    = in_accept;

  // Decision and table update, evaluated when the request commits.
  logic [CW-1:0] free_now, amount, new_count;
  logic          granted, clamped, unknown, full;

  always_comb begin
    free_now  = cpct_pkg::free_slots(max_packets_r, total_r);
    granted   = 1'b0;
    clamped   = 1'b0;
    unknown   = 1'b0;
    full      = 1'b0;
    amount    = '0;
    new_count = '0;
    total_nxt = total_r;
    wr.en     = 1'b0;
    wr.valid  = 1'b0;
    wr.handle = res_r.handle;
    wr.count  = '0;
    wr_idx    = res_hit_idx_r;
    case (mode_r)
      cpct_pkg::MODE_SEND: begin
        if (tx_enabled_r && (free_now != '0)) begin
          if (res_r.hit) begin
            wr.en    = 1'b1;
            wr.valid = 1'b1;
            wr.count = CW'(res_r.count + 1'b1);
            granted  = 1'b1;
          end else if (res_r.free_seen) begin
            wr.en    = 1'b1;
            wr.valid = 1'b1;
            wr.count = CW'(1);
            wr_idx   = res_free_idx_r;
            granted  = 1'b1;
          end else begin
            full = 1'b1;
          end
          if (granted) begin
            total_nxt = CW'(total_r + 1'b1);
          end
        end
      end
      cpct_pkg::MODE_REPORT: begin
        if (!res_r.hit) begin
          unknown = 1'b1;
        end else begin
          if (report_r > cpct_pkg::REPORT_W'(res_r.count)) begin
            clamped = 1'b1;
            amount  = res_r.count;
          end else begin
            amount  = report_r[CW-1:0];
          end
          new_count = CW'(res_r.count - amount);
          wr.en     = 1'b1;
          wr.valid  = (new_count != '0);
          wr.count  = new_count;
          total_nxt = (total_r > amount) ? CW'(total_r - amount) : '0;
        end
      end
      cpct_pkg::MODE_CLEAR: begin
        if (!res_r.hit) begin
          unknown = 1'b1;
        end else begin
          wr.en     = 1'b1;
          wr.valid  = 1'b0;
          total_nxt = (total_r > res_r.count) ? CW'(total_r - res_r.count) : '0;
        end
      end
      default: ;
    endcase
    if (!commit) begin
      wr.en     = 1'b0;
      total_nxt = total_r;
    end
    out_data_nxt = {4'b0000, full, unknown, clamped,
                    cpct_pkg::free_slots(max_packets_r, total_nxt), granted};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpct_pkg::ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r   <= in_tuser;
      report_r <= in_tdata[cpct_pkg::HANDLE_W +: cpct_pkg::REPORT_W];
    end
    if (last_seen) begin
      res_r          <= tok[TABLE_ENTRIES];
      res_hit_idx_r  <= hidx[TABLE_ENTRIES];
      res_free_idx_r <= fidx[TABLE_ENTRIES];
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- test/tb_completed_packet_credit_tracker_core.sv -----
// ---------------------------------------------------------------------------
// tb_completed_packet_credit_tracker_core: self-checking bench for the tracker
// Drives send, completed-packets, clear and unused requests through the
// stream ports, predicts each result from a private copy of the handle table,
// the running total and the two registers, and compares every result field by
// field. Both sides idle in random bursts, and one phase holds the result side
// off long enough that the block stalls its request side.
// ---------------------------------------------------------------------------
module tb_completed_packet_credit_tracker_core;

  // The block has no code for the fourth kind or for the upper two register
  // indexes, so the bench names them itself.
  localparam logic [cpct_pkg::MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam logic [cpct_pkg::CFG_AW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [cpct_pkg::CFG_AW-1:0] REG_SPARE_HI = 2'd3;

  localparam int unsigned TBL_N = 16;

  // The limit leaves a wide margin over a run of about 1100 requests with
  // random idle bursts on each side, and over the long hold-off.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 4 * (TBL_N + 2);
  localparam int unsigned PRINT_CAP   = 40;

  // One result as the block reports it.
  typedef struct packed {
    logic                         granted;
    logic [cpct_pkg::COUNT_W-1:0] free_slots;
    logic                         clamped;
    logic                         unknown_handle;
    logic                         table_full;
  } credit_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [cpct_pkg::IN_DW-1:0]    in_tdata  = '0;
  logic [cpct_pkg::MODE_W-1:0]   in_tuser  = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [cpct_pkg::OUT_DW-1:0]   out_tdata;
  logic                          cfg_we    = 1'b0;
  logic [cpct_pkg::CFG_AW-1:0]   cfg_addr  = '0;
  logic [cpct_pkg::CFG_DW-1:0]   cfg_wdata = '0;

  // Private copy of the block's table, total and registers.
  logic                          tbl_valid  [TBL_N];
  logic [cpct_pkg::HANDLE_W-1:0] tbl_handle [TBL_N];
  logic [cpct_pkg::COUNT_W-1:0]  tbl_count  [TBL_N];
  logic [cpct_pkg::COUNT_W-1:0]  tbl_total;
  logic [cpct_pkg::COUNT_W-1:0]  lim_packets;
  logic                          tx_on;

  credit_result_t credit_results_due [$];
  credit_result_t oldest_due;

  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;
  bit          quiet         = 1'b0;

  completed_packet_credit_tracker_core #(
    .TABLE_ENTRIES(TBL_N)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Free slots as the block computes them: the limit minus the total, never
  // below zero, which also covers a limit written under the current total.
  function automatic logic [cpct_pkg::COUNT_W-1:0] slots_left();
    return (lim_packets > tbl_total) ? cpct_pkg::COUNT_W'(lim_packets - tbl_total) : '0;
  endfunction

  // Takes an amount off the running total, floored at zero.
  function automatic void drop_total(input logic [cpct_pkg::COUNT_W-1:0] amount);
    tbl_total = (tbl_total > amount) ? cpct_pkg::COUNT_W'(tbl_total - amount) : '0;
  endfunction

  // Works out the result of one accepted request and applies it to the
  // private table. Flags that do not belong to the request's kind stay low.
  function automatic credit_result_t predict_credit(
      input logic [cpct_pkg::MODE_W-1:0]   m,
      input logic [cpct_pkg::HANDLE_W-1:0] h,
      input logic [cpct_pkg::REPORT_W-1:0] rc);
    credit_result_t               r;
    int                           hit;
    int                           spare;
    logic [cpct_pkg::COUNT_W-1:0] amount;
    r     = '0;
    hit   = -1;
    spare = -1;
    for (int i = TBL_N - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_handle[i] == h) hit = i;
      if (!tbl_valid[i]) spare = i;
    end
    case (m)
      cpct_pkg::MODE_SEND: begin
        // A refusal for lack of a slot or while sending is disabled never
        // raises table_full; only a missing entry does.
        if (tx_on && slots_left() != '0) begin
          if (hit < 0 && spare >= 0) begin
            // A new handle takes the lowest-numbered free entry.
            tbl_valid[spare]  = 1'b1;
            tbl_handle[spare] = h;
            tbl_count[spare]  = '0;
            hit               = spare;
          end
          if (hit < 0) begin
            r.table_full = 1'b1;
          end else begin
            tbl_count[hit] = tbl_count[hit] + 1'b1;
            tbl_total      = tbl_total + 1'b1;
            r.granted      = 1'b1;
          end
        end
      end
      cpct_pkg::MODE_REPORT: begin
        if (hit < 0) begin
          r.unknown_handle = 1'b1;
        end else begin
          if (rc > cpct_pkg::REPORT_W'(tbl_count[hit])) begin
            r.clamped = 1'b1;
            amount    = tbl_count[hit];
          end else begin
            amount = rc[cpct_pkg::COUNT_W-1:0];
          end
          tbl_count[hit] = tbl_count[hit] - amount;
          drop_total(amount);
          if (tbl_count[hit] == '0) tbl_valid[hit] = 1'b0;
        end
      end
      cpct_pkg::MODE_CLEAR: begin
        if (hit < 0) begin
          r.unknown_handle = 1'b1;
        end else begin
          drop_total(tbl_count[hit]);
          tbl_count[hit] = '0;
          tbl_valid[hit] = 1'b0;
        end
      end
      default: begin
        // The unused kind leaves everything as it is.
      end
    endcase
    r.free_slots = slots_left();
    return r;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at result %0d: %s expected %0d got %0d",
               results_seen, what, exp_v, got_v);
  endtask

  // Offers one request and holds it until the block takes it. The expected
  // result is queued at the edge of acceptance. Afterwards the request side
  // may go idle for a short random burst.
  task automatic send_request(input logic [cpct_pkg::MODE_W-1:0]   m,
                              input logic [cpct_pkg::HANDLE_W-1:0] h,
                              input logic [cpct_pkg::REPORT_W-1:0] rc);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= cpct_pkg::IN_DW'({rc, h});
    do @(posedge clk); while (!in_tready);
    credit_results_due.push_back(predict_credit(m, h, rc));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every result is back, so the block is idle and registers may
  // be written. Each request gives a result, so an empty queue means idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (credit_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the private copy follows it, and indexes with no
  // register behind them are ignored.
  task automatic write_reg(input logic [cpct_pkg::CFG_AW-1:0] idx,
                           input logic [cpct_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cpct_pkg::REG_MAX_PACKETS: lim_packets = val;
      cpct_pkg::REG_TX_ENABLED:  tx_on       = val[0];
      default: begin
      end
    endcase
  endtask

  // Right after reset: sending is disabled, the limit is eight and the table
  // is empty, so every handle is unknown. Writes to the spare indexes must
  // change nothing, and only bit 0 of the enable register counts.
  task automatic test_after_reset();
    send_request(MODE_UNUSED, 12'h000, 16'h0000);
    send_request(cpct_pkg::MODE_SEND, 12'h123, 16'h0001);
    send_request(cpct_pkg::MODE_REPORT, 12'hFFF, 16'hFFFF);
    send_request(cpct_pkg::MODE_CLEAR, 12'h000, 16'h0000);
    drain();
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    write_reg(cpct_pkg::REG_TX_ENABLED, 8'hFE);
    send_request(cpct_pkg::MODE_SEND, 12'h001, 16'hFFFF);
    drain();
    // With no slots at all a send is refused even though sending is enabled.
    write_reg(cpct_pkg::REG_MAX_PACKETS, 8'h00);
    write_reg(cpct_pkg::REG_TX_ENABLED, 8'h01);
    send_request(cpct_pkg::MODE_SEND, 12'h001, 16'h0000);
    drain();
  endtask

  // Grants, a zero report, a report that is clamped and frees the entry, an
  // exact report, and clears of known and unknown handles, at the extremes
  // of the handle and count fields.
  task automatic test_send_and_report();
    write_reg(cpct_pkg::REG_MAX_PACKETS, 8'hFF);
    send_request(cpct_pkg::MODE_SEND, 12'h000, 16'hFFFF);
    send_request(cpct_pkg::MODE_SEND, 12'hFFF, 16'h0000);
    send_request(cpct_pkg::MODE_SEND, 12'hFFF, 16'hAAAA);
    send_request(cpct_pkg::MODE_REPORT, 12'hFFF, 16'h0000);
    send_request(cpct_pkg::MODE_REPORT, 12'hFFF, 16'hFFFF);
    send_request(cpct_pkg::MODE_REPORT, 12'h000, 16'h0001);
    send_request(cpct_pkg::MODE_REPORT, 12'h000, 16'h0001);
    send_request(cpct_pkg::MODE_SEND, 12'h555, 16'h5555);
    send_request(cpct_pkg::MODE_CLEAR, 12'h555, 16'hFFFF);
    send_request(cpct_pkg::MODE_CLEAR, 12'h555, 16'h0000);
    send_request(MODE_UNUSED, 12'hFFF, 16'hFFFF);
    drain();
  endtask

  // Fills all entries, checks that a new handle is refused with table_full
  // while a known one is still granted, then frees one entry and reuses it.
  task automatic test_table_full();
    for (int i = 0; i < TBL_N; i++)
      send_request(cpct_pkg::MODE_SEND, cpct_pkg::HANDLE_W'(12'h800 + i), 16'h0000);
    send_request(cpct_pkg::MODE_SEND, 12'h8FF, 16'h0000);
    send_request(cpct_pkg::MODE_SEND, 12'h805, 16'h0000);
    send_request(cpct_pkg::MODE_REPORT, 12'h803, 16'h0001);
    send_request(cpct_pkg::MODE_SEND, 12'h8FF, 16'h0000);
    drain();
  endtask

  // Lowers the limit below what is pending: free_slots reads zero and sends
  // are refused without table_full until clears bring the total down.
  task automatic test_limit_lowered();
    write_reg(cpct_pkg::REG_MAX_PACKETS, 8'h02);
    send_request(MODE_UNUSED, 12'h000, 16'h0000);
    send_request(cpct_pkg::MODE_SEND, 12'h8FF, 16'h0000);
    for (int i = 0; i < TBL_N; i++)
      send_request(cpct_pkg::MODE_CLEAR, cpct_pkg::HANDLE_W'(12'h800 + i), 16'h0000);
    send_request(cpct_pkg::MODE_CLEAR, 12'h8FF, 16'h0000);
    send_request(cpct_pkg::MODE_SEND, 12'h8FF, 16'h0000);
    drain();
  endtask

  // Random traffic over a small pool of handles, so that entries fill up,
  // drain and get reused. Most requests are sends and small reports; a tenth
  // are noise with any kind, any handle and any count.
  task automatic random_traffic(input int unsigned n, input int unsigned pool_size);
    logic [cpct_pkg::HANDLE_W-1:0] pool [$];
    logic [cpct_pkg::HANDLE_W-1:0] h;
    logic [cpct_pkg::REPORT_W-1:0] rc;
    int unsigned                   pick;
    for (int i = 0; i < pool_size; i++) pool.push_back(cpct_pkg::HANDLE_W'($urandom));
    pool[0] = '1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      h    = pool[$urandom_range(0, pool_size - 1)];
      if (pick < 55) begin
        send_request(cpct_pkg::MODE_SEND, h, cpct_pkg::REPORT_W'($urandom));
      end else if (pick < 80) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)      rc = cpct_pkg::REPORT_W'($urandom_range(0, 3));
        else if (pick < 9) rc = cpct_pkg::REPORT_W'($urandom_range(4, 20));
        else               rc = cpct_pkg::REPORT_W'($urandom);
        send_request(cpct_pkg::MODE_REPORT, h, rc);
      end else if (pick < 90) begin
        send_request(cpct_pkg::MODE_CLEAR, h, cpct_pkg::REPORT_W'($urandom));
      end else begin
        send_request(cpct_pkg::MODE_W'($urandom_range(0, 3)),
                     cpct_pkg::HANDLE_W'($urandom), cpct_pkg::REPORT_W'($urandom));
      end
    end
  endtask

  // Ten phases of random traffic, each under its own register setting. One
  // phase starts with a long hold-off on the result side, and the last one
  // runs with no idling on either side.
  task automatic test_random();
    logic [cpct_pkg::CFG_DW-1:0] lim;
    logic                        en;
    for (int p = 0; p < 10; p++) begin
      drain();
      en = 1'b1;
      case (p)
        0: lim = 8'hFF;
        1: lim = 8'h01;
        2: lim = 8'h00;
        3: lim = 8'd20;
        4: begin
          lim = 8'hFF;
          en  = 1'b0;
        end
        5: lim = 8'd3;
        default: lim = cpct_pkg::CFG_DW'($urandom_range(10, 255));
      endcase
      write_reg(cpct_pkg::REG_MAX_PACKETS, lim);
      write_reg(cpct_pkg::REG_TX_ENABLED,
                (cpct_pkg::CFG_DW'($urandom) & ~cpct_pkg::CFG_DW'(1)) |
                cpct_pkg::CFG_DW'(en));
      if ($urandom_range(0, 2) == 0)
        write_reg(cpct_pkg::CFG_AW'($urandom_range(2, 3)), cpct_pkg::CFG_DW'($urandom));
      if (p == 3) hold_left = 300;
      if (p == 9) quiet = 1'b1;
      random_traffic((p == 2) ? 40 : 110, (p % 3 == 1) ? 8 : 20);
    end
  endtask

  // Result side: ready in random bursts, a long hold-off on request from a
  // test, and always ready once the run goes quiet.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Each result taken at an edge is compared with the oldest expectation.
  // The padding above table_full must read zero as well.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (credit_results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding, data", 0, 32'(out_tdata));
      end else begin
        oldest_due = credit_results_due.pop_front();
        if (out_tdata[0] !== oldest_due.granted)
          report_mismatch("granted", 32'(oldest_due.granted), 32'(out_tdata[0]));
        if (out_tdata[8:1] !== oldest_due.free_slots)
          report_mismatch("free_slots", 32'(oldest_due.free_slots), 32'(out_tdata[8:1]));
        if (out_tdata[9] !== oldest_due.clamped)
          report_mismatch("clamped", 32'(oldest_due.clamped), 32'(out_tdata[9]));
        if (out_tdata[10] !== oldest_due.unknown_handle)
          report_mismatch("unknown_handle", 32'(oldest_due.unknown_handle),
                          32'(out_tdata[10]));
        if (out_tdata[11] !== oldest_due.table_full)
          report_mismatch("table_full", 32'(oldest_due.table_full), 32'(out_tdata[11]));
        if (out_tdata[cpct_pkg::OUT_DW-1:12] !== '0)
          report_mismatch("padding", 0, 32'(out_tdata[cpct_pkg::OUT_DW-1:12]));
      end
      results_seen++;
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_completed_packet_credit_tracker_core: FAIL");
    $finish;
  end

  initial begin
    // The private copy starts where the block's reset leaves it.
    for (int i = 0; i < TBL_N; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_handle[i] = '0;
      tbl_count[i]  = '0;
    end
    tbl_total   = '0;
    lim_packets = cpct_pkg::MAX_PACKETS_RST;
    tx_on       = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_send_and_report();
    test_table_full();
    test_limit_lowered();
    test_random();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_completed_packet_credit_tracker_core: PASS");
    end else begin
      $display("tb_completed_packet_credit_tracker_core: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cpct_pkg.sv
src/cpct_cell.sv
src/completed_packet_credit_tracker_core.sv
test/tb_completed_packet_credit_tracker_core.sv
